// ----- rtl/mgpb_pkg.sv -----
// Shared constants, register codes and control/status types for the moving glare block.
package mgpb_pkg;

  // Default parameter values
  localparam int MAX_PIXELS_DEF    = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // Port widths
  localparam int ELAPSED_W  = 16;
  localparam int IDX_W      = 6;
  localparam int COLOR_W    = 8;
  localparam int EXP_W      = 4;
  localparam int PERIOD_W   = 12;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // full travel time in ms fits in this many bits
  localparam int SPAN_W = 22;

  localparam int MS_PER_SEC = 1000;
  localparam int EPS_DEN    = 10000;

  localparam logic [COLOR_W-1:0] FULL_VALUE = 8'd255;
  localparam logic [COLOR_W-1:0] DIM_FLOOR  = 8'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HUE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FORWARD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRAVEL_TIME = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 3'd5;

  // Controller -> datapath
  typedef struct packed {
    logic capture;    // latch elapsed time and span
    logic load_step;  // start step division
    logic div_step;   // one quotient bit
    logic move;       // update midpoint, clear pixel counter
    logic load_pix;   // start x division
    logic shape_r;    // distance -> ratio
    logic shape_t;    // ratio -> base of the power
    logic pow_step;   // one multiply of the power loop
    logic load_out;   // write result register
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_last;
    logic pow_done;
    logic count_zero;
    logic pix_last;
    logic out_full;
  } sts_t;

endpackage

// ----- rtl/mgpb_ctrl.sv -----
// Sequencer for frame update and per-pixel brightness computation.
module mgpb_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  mgpb_pkg::sts_t sts_i,
  output mgpb_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD_STEP,
    ST_DIV_STEP,
    ST_MOVE,
    ST_LOAD_PIX,
    ST_DIV_PIX,
    ST_SHAPE_R,
    ST_SHAPE_T,
    ST_POW,
    ST_OUT
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_LOAD_STEP;
        end
      end
      ST_LOAD_STEP: begin
        cmd_o.load_step = 1'b1;
        state_d         = ST_DIV_STEP;
      end
      ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = sts_i.count_zero ? ST_IDLE : ST_LOAD_PIX;
      end
      ST_LOAD_PIX: begin
        cmd_o.load_pix = 1'b1;
        state_d        = ST_DIV_PIX;
      end
      ST_DIV_PIX: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = ST_SHAPE_R;
      end
      ST_SHAPE_R: begin
        cmd_o.shape_r = 1'b1;
        state_d       = ST_SHAPE_T;
      end
      ST_SHAPE_T: begin
        cmd_o.shape_t = 1'b1;
        state_d       = ST_POW;
      end
      ST_POW: begin
        if (sts_i.pow_done) begin
          state_d = ST_OUT;
        end else begin
          cmd_o.pow_step = 1'b1;
        end
      end
      ST_OUT: begin
        // wait for the previous result to drain
        if (!sts_i.out_full) begin
          cmd_o.load_out = 1'b1;
          state_d        = sts_i.pix_last ? ST_IDLE : ST_LOAD_PIX;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/mgpb_datapath.sv -----
// Config registers, shared divider, midpoint, power loop and result register.
module mgpb_datapath #(
  parameter int MAX_PIXELS    = mgpb_pkg::MAX_PIXELS_DEF,
  parameter int FRACTION_BITS = mgpb_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [mgpb_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mgpb_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [mgpb_pkg::ELAPSED_W-1:0]     elapsed_ms_i,
  input  logic                               out_ready_i,
  output logic                               out_valid_o,
  output logic [mgpb_pkg::IDX_W-1:0]         pixel_index_o,
  output logic [mgpb_pkg::COLOR_W-1:0]       out_hue_o,
  output logic [mgpb_pkg::COLOR_W-1:0]       out_sat_o,
  output logic [mgpb_pkg::COLOR_W-1:0]       brightness_o,
  output logic                               last_o,
  input  mgpb_pkg::cmd_t                     cmd_i,
  output mgpb_pkg::sts_t                     sts_o
);

  localparam int F      = FRACTION_BITS;
  localparam int SPAN_W = mgpb_pkg::SPAN_W;
  localparam int CNT_W  = mgpb_pkg::CNT_W;
  localparam int IDX_W  = mgpb_pkg::IDX_W;
  localparam int EXP_W_L = mgpb_pkg::EXP_W;
  localparam int DCNT_W = $clog2(F + 1);
  localparam int EPS_INT = ((2 ** FRACTION_BITS) + mgpb_pkg::EPS_DEN - 1) / mgpb_pkg::EPS_DEN;

  localparam logic [F:0]        ONE_Q   = {1'b1, {F{1'b0}}};
  localparam logic [F:0]        HALF_Q  = ONE_Q >> 1;
  localparam logic [F:0]        EPS_Q   = (F + 1)'(EPS_INT);
  localparam logic [CNT_W-1:0]  MAX_CNT = CNT_W'(MAX_PIXELS);
  localparam logic [SPAN_W-1:0] MS_K    = SPAN_W'(mgpb_pkg::MS_PER_SEC);

  // Configuration registers
  logic [mgpb_pkg::COLOR_W-1:0]  hue_q, sat_q;
  logic [mgpb_pkg::EXP_W-1:0]    exp_q;
  logic                          fwd_q;
  logic [mgpb_pkg::PERIOD_W-1:0] period_q;
  logic [CNT_W-1:0]              count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hue_q    <= '0;
      sat_q    <= 8'd255;
      exp_q    <= 4'd2;
      fwd_q    <= 1'b1;
      period_q <= 12'd1;
      count_q  <= 7'd64;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        mgpb_pkg::REG_HUE:         hue_q    <= cfg_data_i[mgpb_pkg::COLOR_W-1:0];
        mgpb_pkg::REG_SATURATION:  sat_q    <= cfg_data_i[mgpb_pkg::COLOR_W-1:0];
        mgpb_pkg::REG_EXPONENT:    exp_q    <= cfg_data_i[mgpb_pkg::EXP_W-1:0];
        mgpb_pkg::REG_FORWARD:     fwd_q    <= cfg_data_i[0];
        mgpb_pkg::REG_TRAVEL_TIME: period_q <= cfg_data_i[mgpb_pkg::PERIOD_W-1:0];
        mgpb_pkg::REG_PIXEL_COUNT: count_q  <= cfg_data_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0]              count_eff;
  logic [mgpb_pkg::PERIOD_W-1:0] period_eff;
  assign count_eff  = (count_q > MAX_CNT) ? MAX_CNT : count_q;
  assign period_eff = (period_q == '0) ? mgpb_pkg::PERIOD_W'(1) : period_q;

  // Frame capture
  logic [mgpb_pkg::ELAPSED_W-1:0] elapsed_q;
  logic [SPAN_W-1:0]              span_q;
  logic [SPAN_W-1:0]              elapsed_ext, elapsed_clamp;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      elapsed_q <= elapsed_ms_i;
      span_q    <= SPAN_W'({{(SPAN_W - mgpb_pkg::PERIOD_W){1'b0}}, period_eff} * MS_K);
    end
  end

  assign elapsed_ext   = SPAN_W'(elapsed_q);
  assign elapsed_clamp = (elapsed_ext > span_q) ? span_q : elapsed_ext;

  // Pixel counter, cleared on each midpoint update
  logic [IDX_W-1:0] pix_q;

  // Restoring divider, one quotient bit a cycle; first bit is the integer bit
  logic [SPAN_W-1:0] rem_q, dvs_q;
  logic [F:0]        quot_q;
  logic [DCNT_W-1:0] div_cnt_q;
  logic [SPAN_W:0]   div_shift, div_diff;
  logic              div_ge;

  assign div_shift = (div_cnt_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
  assign div_ge    = div_shift >= {1'b0, dvs_q};
  assign div_diff  = div_shift - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_step) begin
      rem_q     <= elapsed_clamp;
      dvs_q     <= span_q;
      quot_q    <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.load_pix) begin
      rem_q     <= SPAN_W'(pix_q);
      dvs_q     <= SPAN_W'(count_eff);
      quot_q    <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= div_ge ? div_diff[SPAN_W-1:0] : div_shift[SPAN_W-1:0];
      quot_q    <= {quot_q[F-1:0], div_ge};
      div_cnt_q <= div_cnt_q + 1'b1;
    end
  end

  // Midpoint, kept modulo one
  logic [F-1:0] mid_q;
  logic [F:0]   mid_sum, mid_diff;

  assign mid_sum  = {1'b0, mid_q} + quot_q;
  assign mid_diff = {1'b0, mid_q} - quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      pix_q <= '0;
    end else begin
      if (cmd_i.move) begin
        mid_q <= fwd_q ? mid_sum[F-1:0] : mid_diff[F-1:0];
        pix_q <= '0;
      end else if (cmd_i.load_out) begin
        pix_q <= pix_q + 1'b1;
      end
    end
  end

  // Pixel shape: r = max(1 - |x - m|, eps), t = 2|r - 1/2|
  logic [F-1:0] pix_x, mid_gap;
  logic [F:0]   r_raw, r_q, t_half, t_q, p_q;
  logic [2*F+1:0] pow_prod;
  logic [EXP_W_L-1:0] exp_cnt_q;

  assign pix_x    = quot_q[F-1:0];
  assign mid_gap  = (pix_x > mid_q) ? (pix_x - mid_q) : (mid_q - pix_x);
  assign r_raw    = ONE_Q - {1'b0, mid_gap};
  assign t_half   = (r_q > HALF_Q) ? (r_q - HALF_Q) : (HALF_Q - r_q);
  assign pow_prod = p_q * t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shape_r) begin
      r_q <= (r_raw < EPS_Q) ? EPS_Q : r_raw;
    end
    if (cmd_i.shape_t) begin
      t_q       <= {t_half[F-1:0], 1'b0};
      p_q       <= ONE_Q;
      exp_cnt_q <= '0;
    end else if (cmd_i.pow_step) begin
      p_q       <= pow_prod[2*F:F];
      exp_cnt_q <= exp_cnt_q + 1'b1;
    end
  end

  // Scale to 8 bits, saturate, blank dim pixels
  logic [F+8:0] bright_prod;
  logic [8:0]   bright_raw;
  logic [7:0]   bright_sat, bright_val;

  assign bright_prod = {8'b0, p_q} * (F + 9)'(mgpb_pkg::FULL_VALUE);
  assign bright_raw  = bright_prod[F+8:F];
  assign bright_sat  = (bright_raw > 9'(mgpb_pkg::FULL_VALUE)) ? mgpb_pkg::FULL_VALUE
                                                              : bright_raw[7:0];
  assign bright_val  = (bright_sat < mgpb_pkg::DIM_FLOOR) ? 8'd0 : bright_sat;

  logic pix_last;
  assign pix_last = ({1'b0, pix_q} + 1'b1) == count_eff;

  // Result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      pixel_index_o <= pix_q;
      out_hue_o     <= hue_q;
      out_sat_o     <= sat_q;
      brightness_o  <= bright_val;
      last_o        <= pix_last;
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.div_last   = (div_cnt_q == DCNT_W'(F));
  assign sts_o.pow_done   = (exp_cnt_q == exp_q);
  assign sts_o.count_zero = (count_eff == '0);
  assign sts_o.pix_last   = pix_last;
  assign sts_o.out_full   = out_valid_q;

endmodule

// ----- rtl/moving_glare_pixel_brightness_top.sv -----
// Top level of the moving glare brightness engine.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid_i/cfg_ready_o, index, data      | in
//  in      | in_valid_i/in_ready_o, elapsed_ms_i       | in
//  out     | out_valid_o/out_ready_i, pixel + last     | out
//
// One frame request at a time. After acceptance the step load, the bit-serial
// divider and the midpoint move run in order. Each pixel then runs the divider
// for x, two shaping steps, one multiplier pass per exponent, and the result
// load. The result register lets the next pixel be computed while one waits;
// a stalled output holds the sequencer in its load step. Reset zeroes the
// midpoint; registers reload.
module moving_glare_pixel_brightness_top #(
  parameter int MAX_PIXELS    = mgpb_pkg::MAX_PIXELS_DEF,
  parameter int FRACTION_BITS = mgpb_pkg::FRACTION_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mgpb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mgpb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mgpb_pkg::ELAPSED_W-1:0]  elapsed_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mgpb_pkg::IDX_W-1:0]      pixel_index_o,
  output logic [mgpb_pkg::COLOR_W-1:0]    out_hue_o,
  output logic [mgpb_pkg::COLOR_W-1:0]    out_sat_o,
  output logic [mgpb_pkg::COLOR_W-1:0]    brightness_o,
  output logic                            last_o
);

  mgpb_pkg::cmd_t cmd;
  mgpb_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mgpb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mgpb_datapath #(
    .MAX_PIXELS    (MAX_PIXELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .elapsed_ms_i  (elapsed_ms_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .pixel_index_o (pixel_index_o),
    .out_hue_o     (out_hue_o),
    .out_sat_o     (out_sat_o),
    .brightness_o  (brightness_o),
    .last_o        (last_o),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
